>>> rtl/core/pip_pkg.sv
// Shared types and constants for the point-in-polygon test block.
// Used by pip_cell, pip_edge_eval and point_in_polygon_test; no dependencies.
`default_nettype none

package pip_pkg;

    localparam int COORD_W           = 16;
    localparam int DIFF_W            = COORD_W + 1;
    localparam int PROD_W            = 2 * DIFF_W;
    localparam int VCOUNT_W          = 7;
    localparam int ACT_W             = 2;
    localparam int S_TDATA_W         = 2 * COORD_W;
    localparam int M_TDATA_W         = 16;
    localparam int M_PAD_W           = M_TDATA_W - VCOUNT_W - 2;
    localparam int MAX_VERTICES_DFLT = 64;
    localparam int MIN_POLY_VERTICES = 3;

    // Drain counter value at which the parity is final and the test result is loaded
    localparam logic [1:0] DRAIN_CYC = 2'd2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    // Edge from vertex a to vertex b (b is the vertex before a)
    typedef struct packed {
        t_vertex a;
        t_vertex b;
    } t_edge;

endpackage

`default_nettype wire

>>> rtl/core/pip_cell.sv
// One storage cell of the vertex chain: holds a vertex, loads on append,
// takes its neighbor's vertex when the chain rotates. Depends on pip_pkg.
`default_nettype none

module pip_cell (
    input  wire            i_clk,
    input  wire            i_load,
    input  wire            i_shift,
    input  pip_pkg::t_vertex i_load_vtx,
    input  pip_pkg::t_vertex i_nbr_vtx,
    output pip_pkg::t_vertex o_vtx
);

    pip_pkg::t_vertex r_vtx;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vtx <= i_load_vtx;
        end else if (i_shift) begin
            r_vtx <= i_nbr_vtx;
        end
    end

    assign o_vtx = r_vtx;

endmodule

`default_nettype wire

>>> rtl/core/pip_edge_eval.sv
// Pipelined edge crossing unit: differences, cross products, compare and
// parity toggle, one edge per cycle. Depends on pip_pkg.
`default_nettype none

module pip_edge_eval (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_clear,
    input  wire                                i_edge_vld,
    input  pip_pkg::t_edge                     i_edge,
    input  wire signed [pip_pkg::COORD_W-1:0]  i_px,
    input  wire signed [pip_pkg::COORD_W-1:0]  i_py,
    output logic                               o_parity
);

    logic signed [pip_pkg::DIFF_W-1:0] r_dax, r_dy, r_dbx, r_dpy;
    logic                              r_v1, r_cross1;
    logic signed [pip_pkg::PROD_W-1:0] r_lhs, r_rhs;
    logic                              r_v2, r_dypos;
    logic                              r_parity;
    logic                              w_straddle;
    logic                              w_left;

    assign w_straddle = (i_edge.a.y > i_py) != (i_edge.b.y > i_py);

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        r_dax    <= pip_pkg::DIFF_W'(i_px) - pip_pkg::DIFF_W'(i_edge.a.x);
        r_dy     <= pip_pkg::DIFF_W'(i_edge.b.y) - pip_pkg::DIFF_W'(i_edge.a.y);
        r_dbx    <= pip_pkg::DIFF_W'(i_edge.b.x) - pip_pkg::DIFF_W'(i_edge.a.x);
        r_dpy    <= pip_pkg::DIFF_W'(i_py) - pip_pkg::DIFF_W'(i_edge.a.y);
        r_cross1 <= w_straddle;
    end

    // stage 2: cross products
    always_ff @(posedge i_clk) begin
        r_lhs   <= r_dax * r_dy;
        r_rhs   <= r_dbx * r_dpy;
        r_dypos <= r_dy > 0;
    end

    // reverse the compare sense when the edge runs downward
    assign w_left = r_dypos ? (r_lhs < r_rhs) : (r_lhs > r_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_v1 <= i_edge_vld;
            r_v2 <= r_v1 && r_cross1;
            if (i_clear) begin
                r_parity <= 1'b0;
            end else if (r_v2 && w_left) begin
                r_parity <= !r_parity;
            end
        end
    end

    assign o_parity = r_parity;

endmodule

`default_nettype wire

>>> rtl/core/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon test: vertex chain, rotation
// control and output register. Depends on pip_pkg, pip_cell, pip_edge_eval.
//
// Channel   Dir  Handshake               Payload
// s (in)    in   i_s_tvalid/o_s_tready   tuser: action; tdata: coord_x, coord_y
// m (out)   out  o_m_tvalid/i_m_tready   tdata: is_inside, vertex_count, dropped
//
// Clear and append finish in the cycle they are accepted; the result is
// valid the next cycle. A test rotates the whole vertex chain once past cell
// 0, which feeds the edge unit one step at a time; after the last step the
// edge pipeline drains and the test result is loaded into the output register.
// Reset is synchronous, active low, and empties the polygon. Input is held off
// while a test runs or while an earlier result is still waiting at the output.
`default_nettype none

module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DFLT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [pip_pkg::S_TDATA_W-1:0]    i_s_tdata,  // coord_x, coord_y
    input  wire  [pip_pkg::ACT_W-1:0]        i_s_tuser,  // action
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [pip_pkg::M_TDATA_W-1:0]    o_m_tdata   // is_inside, vertex_count,
                                                         // dropped, zero pad
);

    localparam int             CW   = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0]  FULL = CW'(MAX_VERTICES);
    localparam logic [CW-1:0]  MINV = CW'(pip_pkg::MIN_POLY_VERTICES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                           r_state;
    logic [CW-1:0]                        r_step;
    logic [1:0]                           r_drain;
    logic [CW-1:0]                        r_count, n_count;
    logic                                 r_dropped, n_dropped;
    pip_pkg::t_vertex                     r_first, r_prev;
    logic signed [pip_pkg::COORD_W-1:0]   r_px, r_py;
    logic                                 r_ovld;
    logic                                 r_inside;
    logic [pip_pkg::VCOUNT_W-1:0]         r_vcount;
    logic                                 r_odrop;

    logic                                 w_accept;
    logic [pip_pkg::ACT_W-1:0]            w_act;
    pip_pkg::t_vertex                     w_in_vtx;
    logic                                 w_wr;
    logic                                 w_shift;
    logic                                 w_test_start;
    logic                                 w_edge_vld;
    pip_pkg::t_edge                       w_edge;
    logic                                 w_parity;
    logic                                 w_done;
    logic                                 w_out_load;
    pip_pkg::t_vertex                     w_cell [MAX_VERTICES];

    assign w_act        = i_s_tuser;
    assign w_in_vtx.x   = i_s_tdata[pip_pkg::COORD_W-1:0];
    assign w_in_vtx.y   = i_s_tdata[pip_pkg::S_TDATA_W-1:pip_pkg::COORD_W];
    assign o_s_tready   = (r_state == ST_IDLE) && (!r_ovld || i_m_tready);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_wr         = w_accept && (w_act == pip_pkg::ACT_APPEND) && (r_count != FULL);
    assign w_test_start = w_accept && (w_act == pip_pkg::ACT_TEST);
    assign w_shift      = (r_state == ST_RUN) && (r_step != FULL);
    assign w_done       = (r_state == ST_DRAIN) && (r_drain == pip_pkg::DRAIN_CYC);
    assign w_out_load   = (w_accept && (w_act == pip_pkg::ACT_CLEAR ||
                                        w_act == pip_pkg::ACT_APPEND)) || w_done;

    // Vertex chain: cell k holds vertex k; rotation moves each vertex one
    // cell toward cell 0, and cell 0 wraps to the far end.
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        pip_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_wr && (r_count == CW'(k))),
            .i_shift    (w_shift),
            .i_load_vtx (w_in_vtx),
            .i_nbr_vtx  (w_cell[(k + 1) % MAX_VERTICES]),
            .o_vtx      (w_cell[k])
        );
    end

    // Step s presents vertex s at cell 0; edges run from step 1 to step n,
    // and step n closes the polygon back to the saved first vertex.
    assign w_edge_vld = (r_state == ST_RUN) && (r_step != '0) && (r_step <= r_count);
    assign w_edge.a   = (r_step == r_count) ? r_first : w_cell[0];
    assign w_edge.b   = r_prev;

    pip_edge_eval u_edge_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_test_start),
        .i_edge_vld (w_edge_vld),
        .i_edge     (w_edge),
        .i_px       (r_px),
        .i_py       (r_py),
        .o_parity   (w_parity)
    );

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_accept) begin
            case (w_act)
                pip_pkg::ACT_CLEAR: begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
                pip_pkg::ACT_APPEND: begin
                    if (r_count != FULL) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_drain   <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
            // hold a waiting result until it transfers, load a new one when due
            r_ovld    <= w_out_load || (r_ovld && !i_m_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (w_act == pip_pkg::ACT_TEST)) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == FULL) begin
                        r_state <= ST_DRAIN;
                        r_drain <= '0;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_drain <= r_drain + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= w_in_vtx.x;
            r_py <= w_in_vtx.y;
        end
        if (r_state == ST_RUN) begin
            r_prev <= w_cell[0];
            if (r_step == '0) begin
                r_first <= w_cell[0];
            end
        end
        if (w_accept && (w_act == pip_pkg::ACT_CLEAR || w_act == pip_pkg::ACT_APPEND)) begin
            r_inside <= 1'b0;
            r_vcount <= pip_pkg::VCOUNT_W'(n_count);
            r_odrop  <= n_dropped;
        end else if (w_done) begin
            // polygons under three vertices test outside
            r_inside <= w_parity && (r_count >= MINV);
            r_vcount <= pip_pkg::VCOUNT_W'(r_count);
            r_odrop  <= r_dropped;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {{pip_pkg::M_PAD_W{1'b0}}, r_odrop, r_vcount, r_inside};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("vertex count beyond store depth");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_dropped) |-> $past(r_count) == FULL)
        else $error("drop flag set while store had room");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_accept)
        else $error("transfer accepted during a test");

    a_out_free_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> !r_ovld)
        else $error("output register occupied when test result is due");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for point_in_polygon_test: directed table, then random
// polygons and test points scored against an even-odd crossing-number predictor.
// Depends on pip_pkg and the point_in_polygon_test RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pip_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int NUM_ITEMS   = 650;
    localparam int CALM_AFTER  = 570;
    localparam int DRAIN_LIMIT = pip_pkg::MAX_VERTICES_DFLT + 16;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_ROWS    = 22;

    typedef struct packed {
        logic                         in_poly;
        logic [pip_pkg::VCOUNT_W-1:0] count;
        logic                         dropped;
    } t_poly_answer;

    typedef struct packed {
        logic [pip_pkg::ACT_W-1:0]          act;
        logic signed [pip_pkg::COORD_W-1:0] x;
        logic signed [pip_pkg::COORD_W-1:0] y;
        logic                               typed;
        t_poly_answer                       ans;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [pip_pkg::S_TDATA_W-1:0] i_s_tdata = '0;   // coord_x, coord_y
    logic [pip_pkg::ACT_W-1:0]     i_s_tuser = '0;   // action
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [pip_pkg::M_TDATA_W-1:0] o_m_tdata;        // is_inside, vertex_count, dropped,
                                                     // zero pad

    point_in_polygon_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: stored polygon
    logic signed [pip_pkg::COORD_W-1:0] poly_x [pip_pkg::MAX_VERTICES_DFLT];
    logic signed [pip_pkg::COORD_W-1:0] poly_y [pip_pkg::MAX_VERTICES_DFLT];
    int                                 poly_count = 0;
    logic                               poly_dropped = 1'b0;

    t_poly_answer answers_due [$];
    int           items_sent   = 0;
    int           results_seen = 0;
    int           n_fail       = 0;
    bit           calm         = 1'b0;

    t_stim_row directed_rows [NUM_ROWS];

    function automatic logic signed [pip_pkg::COORD_W-1:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[pip_pkg::COORD_W-1:0];
    endfunction

    // Update the polygon for one action; return 1 if the action yields an answer
    function automatic bit polygon_step(input logic [pip_pkg::ACT_W-1:0] act,
                                        input logic signed [pip_pkg::COORD_W-1:0] px,
                                        input logic signed [pip_pkg::COORD_W-1:0] py,
                                        output t_poly_answer ans);
        longint ax, ay, bx, by, dy, lhs, rhs;
        int     j;
        bit     parity;
        bit     left;
        parity = 1'b0;
        ans = '0;
        case (act)
            pip_pkg::ACT_CLEAR: begin
                poly_count = 0;
                poly_dropped = 1'b0;
            end
            pip_pkg::ACT_APPEND: begin
                if (poly_count < pip_pkg::MAX_VERTICES_DFLT) begin
                    poly_x[poly_count] = px;
                    poly_y[poly_count] = py;
                    poly_count++;
                end else begin
                    poly_dropped = 1'b1;
                end
            end
            pip_pkg::ACT_TEST: begin
                if (poly_count >= pip_pkg::MIN_POLY_VERTICES) begin
                    j = poly_count - 1;
                    for (int i = 0; i < poly_count; i++) begin
                        ax = poly_x[i];
                        ay = poly_y[i];
                        bx = poly_x[j];
                        by = poly_y[j];
                        // strict greater-than on both ends decides a straddle
                        if ((ay > longint'(py)) != (by > longint'(py))) begin
                            dy  = by - ay;
                            lhs = (longint'(px) - ax) * dy;
                            rhs = (bx - ax) * (longint'(py) - ay);
                            left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                            parity ^= left;
                        end
                        j = i;
                    end
                end
            end
            default: return 1'b0;
        endcase
        ans.in_poly = parity;
        ans.count   = poly_count[pip_pkg::VCOUNT_W-1:0];
        ans.dropped = poly_dropped;
        return 1'b1;
    endfunction

    // Enter at a falling edge; return at a falling edge after the transfer
    task automatic send_item(input logic [pip_pkg::ACT_W-1:0] act, input int x,
                             input int y, input bit typed, input t_poly_answer typed_ans);
        t_poly_answer ans;
        logic signed [pip_pkg::COORD_W-1:0] cx, cy;
        cx = sat16(x);
        cy = sat16(y);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {cy, cx};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        if (polygon_step(act, cx, cy, ans))
            answers_due = {answers_due, typed ? typed_ans : ans};
        if (act != ACT_UNUSED)
            items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= pip_pkg::S_TDATA_W'($urandom);
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    function automatic int full_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Clear, build a polygon around a random center (the origin when wide), then probe it
    task automatic polygon_burst(input int n_vert, input int n_test, input bit wide);
        int cx, cy, r, px, py, k, reach;
        int vx [$];
        int vy [$];
        if (wide) begin
            cx = 0;
            cy = 0;
            r  = 32767;
        end else begin
            cx = int'($urandom_range(0, 60000)) - 30000;
            cy = int'($urandom_range(0, 60000)) - 30000;
            r  = $urandom_range(4, 2000);
        end
        send_item(pip_pkg::ACT_CLEAR, full_coord(), full_coord(), 1'b0, '0);
        for (int v = 0; v < n_vert; v++) begin
            px = sat16(cx + int'($urandom_range(0, 2 * r)) - r);
            py = sat16(cy + int'($urandom_range(0, 2 * r)) - r);
            vx = {vx, px};
            vy = {vy, py};
            send_item(pip_pkg::ACT_APPEND, px, py, 1'b0, '0);
        end
        reach = r + r / 4;
        for (int t = 0; t < n_test; t++) begin
            px = cx + int'($urandom_range(0, 2 * reach)) - reach;
            py = cy + int'($urandom_range(0, 2 * reach)) - reach;
            if (n_vert > 0) begin
                k = $urandom_range(0, n_vert - 1);
                case ($urandom_range(0, 4))
                    0: py = vy[k];            // on a vertex's y line
                    1: begin
                        px = vx[k];
                        py = vy[k];
                    end
                    2: begin
                        px = full_coord();
                        py = full_coord();
                    end
                    default: ;
                endcase
            end
            send_item(pip_pkg::ACT_TEST, px, py, 1'b0, '0);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_poly_answer want;
        t_poly_answer got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            got.in_poly = o_m_tdata[0];
            got.count   = o_m_tdata[pip_pkg::VCOUNT_W:1];
            got.dropped = o_m_tdata[pip_pkg::VCOUNT_W+1];
            if (answers_due.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result, actual %h", $time, got);
            end else begin
                want = answers_due.pop_front();
                if (got.in_poly !== want.in_poly) begin
                    n_fail++;
                    $display("%0t: is_inside expected %0d actual %0d",
                             $time, want.in_poly, got.in_poly);
                end
                if (got.count !== want.count) begin
                    n_fail++;
                    $display("%0t: vertex_count expected %0d actual %0d",
                             $time, want.count, got.count);
                end
                if (got.dropped !== want.dropped) begin
                    n_fail++;
                    $display("%0t: dropped expected %0d actual %0d",
                             $time, want.dropped, got.dropped);
                end
            end
        end
    end

    // Result acceptor: random stalls, plus two long hold-offs to back up the input
    initial begin
        int next_hold;
        int held;
        next_hold = 60;
        forever begin
            @(negedge i_clk);
            if (results_seen >= next_hold) begin
                i_m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                next_hold = (next_hold == 60) ? 300 : 32'h7FFF_FFFF;
            end
            if (!calm && $urandom_range(0, 2) == 0)
                i_m_tready <= 1'b0;
            else
                i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
        end
    end

    initial begin
        int iter;
        directed_rows = '{
            '{pip_pkg::ACT_TEST,   16'sd0,     16'sd0,     1'b1, '{1'b0, 7'd0, 1'b0}},
            '{pip_pkg::ACT_APPEND, 16'sh8000,  16'sh8000,  1'b1, '{1'b0, 7'd1, 1'b0}},
            '{pip_pkg::ACT_APPEND, 16'sh7FFF,  16'sh8000,  1'b1, '{1'b0, 7'd2, 1'b0}},
            '{pip_pkg::ACT_TEST,   16'sd0,     16'sd0,     1'b1, '{1'b0, 7'd2, 1'b0}},
            '{pip_pkg::ACT_APPEND, 16'sd0,     16'sh7FFF,  1'b1, '{1'b0, 7'd3, 1'b0}},
            '{pip_pkg::ACT_TEST,   16'sd0,     16'sd0,     1'b0, '0},
            '{pip_pkg::ACT_TEST,   16'sh8000,  16'sh7FFF,  1'b0, '0},
            '{pip_pkg::ACT_TEST,   16'sh7FFF,  16'sh8000,  1'b0, '0},
            '{ACT_UNUSED,          16'shFFFF,  16'shFFFF,  1'b0, '0},
            '{pip_pkg::ACT_TEST,   16'sd0,     -16'sd1,    1'b0, '0},
            '{pip_pkg::ACT_CLEAR,  16'sd0,     16'sd0,     1'b1, '{1'b0, 7'd0, 1'b0}},
            '{pip_pkg::ACT_APPEND, -16'sd100,  -16'sd100,  1'b1, '{1'b0, 7'd1, 1'b0}},
            '{pip_pkg::ACT_APPEND, 16'sd100,   -16'sd100,  1'b1, '{1'b0, 7'd2, 1'b0}},
            '{pip_pkg::ACT_APPEND, 16'sd100,   16'sd100,   1'b1, '{1'b0, 7'd3, 1'b0}},
            '{pip_pkg::ACT_APPEND, -16'sd100,  16'sd100,   1'b1, '{1'b0, 7'd4, 1'b0}},
            '{pip_pkg::ACT_TEST,   16'sd0,     16'sd0,     1'b0, '0},
            '{pip_pkg::ACT_TEST,   -16'sd100,  16'sd0,     1'b0, '0},
            '{pip_pkg::ACT_TEST,   16'sd0,     16'sd100,   1'b0, '0},
            '{pip_pkg::ACT_TEST,   16'sd99,    -16'sd100,  1'b0, '0},
            '{ACT_UNUSED,          16'sh7FFF,  16'sh8000,  1'b0, '0},
            '{pip_pkg::ACT_CLEAR,  16'sh8000,  16'sh7FFF,  1'b1, '{1'b0, 7'd0, 1'b0}},
            '{pip_pkg::ACT_TEST,   16'sd5,     16'sd5,     1'b1, '{1'b0, 7'd0, 1'b0}}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].act, directed_rows[r].x, directed_rows[r].y,
                      directed_rows[r].typed, directed_rows[r].ans);

        iter = 0;
        while (items_sent < NUM_ITEMS) begin
            if (iter == 4 || iter == 45) begin
                // fill the store, and at times run it past full
                polygon_burst(pip_pkg::MAX_VERTICES_DFLT + $urandom_range(0, 4),
                              $urandom_range(2, 4), 1'b0);
            end else if ($urandom_range(0, 9) < 7) begin
                polygon_burst(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                          : $urandom_range(3, 12),
                              $urandom_range(1, 6), $urandom_range(0, 7) == 0);
            end else begin
                send_item(pip_pkg::ACT_W'($urandom_range(0, 3)), full_coord(), full_coord(),
                          1'b0, '0);
            end
            iter++;
        end
        i_s_tvalid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_LIMIT) @(posedge i_clk);

        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
